### hdl/tgr_pkg.sv
// shared types and constants for the touch gesture recognizer
// depends on nothing; used by all modules in hdl
package tgr_pkg;
	localparam int ANGLE_W = 16;
	localparam int ROT_STEP = 3640;
	localparam int CORDIC_N = 32;
	localparam logic [2:0] OP_DOWN = 3'd0;
	localparam logic [2:0] OP_MOVE = 3'd1;
	localparam logic [2:0] OP_LIFT = 3'd2;
	localparam logic [2:0] OP_ATTACH = 3'd3;
	localparam logic [2:0] OP_DETACH = 3'd4;
	localparam logic [1:0] G_TAP = 2'd0;
	localparam logic [1:0] G_LEFT = 2'd1;
	localparam logic [1:0] G_RIGHT = 2'd2;
	localparam logic [1:0] G_ROTATE = 2'd3;
	localparam logic [2:0] REG_CX = 3'd0;
	localparam logic [2:0] REG_CY = 3'd1;
	localparam logic [2:0] REG_MASK = 3'd2;
	localparam logic [2:0] REG_TMOVE = 3'd3;
	localparam logic [2:0] REG_TMS = 3'd4;
	localparam logic [2:0] REG_GRACE = 3'd5;
	localparam logic [2:0] REG_SWIPE = 3'd6;
	localparam logic [2:0] REG_RAD = 3'd7;

	// controller to datapath commands
	typedef struct packed {
		logic load;      // capture input item, compute differences
		logic cordic_init;
		logic cordic_step;
		logic mult_calc; // radius test
		logic down_upd;  // commit touchdown state
		logic move_upd;  // commit move tracking
		logic rot_upd;   // commit angle state
		logic acc_upd;   // compute steps from accumulator
		logic lift_upd;
	} tgr_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic cordic_last;
		logic rot_enabled; // handler bit and radius pass
		logic rot_emit;
		logic lift_emit;
	} tgr_sts_t;

	// arctangent table in 2^-32 turn
	function automatic logic [31:0] cordic_atan(input logic [4:0] i);
		case (i)
			5'd0: cordic_atan = 32'd536870912;
			5'd1: cordic_atan = 32'd316933406;
			5'd2: cordic_atan = 32'd167458907;
			5'd3: cordic_atan = 32'd85004756;
			5'd4: cordic_atan = 32'd42667331;
			5'd5: cordic_atan = 32'd21354465;
			5'd6: cordic_atan = 32'd10679838;
			5'd7: cordic_atan = 32'd5340245;
			5'd8: cordic_atan = 32'd2670163;
			5'd9: cordic_atan = 32'd1335087;
			5'd10: cordic_atan = 32'd667544;
			5'd11: cordic_atan = 32'd333772;
			5'd12: cordic_atan = 32'd166886;
			5'd13: cordic_atan = 32'd83443;
			5'd14: cordic_atan = 32'd41722;
			5'd15: cordic_atan = 32'd20861;
			5'd16: cordic_atan = 32'd10430;
			5'd17: cordic_atan = 32'd5215;
			5'd18: cordic_atan = 32'd2608;
			5'd19: cordic_atan = 32'd1304;
			5'd20: cordic_atan = 32'd652;
			5'd21: cordic_atan = 32'd326;
			5'd22: cordic_atan = 32'd163;
			5'd23: cordic_atan = 32'd81;
			5'd24: cordic_atan = 32'd41;
			5'd25: cordic_atan = 32'd20;
			5'd26: cordic_atan = 32'd10;
			5'd27: cordic_atan = 32'd5;
			5'd28: cordic_atan = 32'd3;
			5'd29: cordic_atan = 32'd1;
			5'd30: cordic_atan = 32'd1;
			default: cordic_atan = 32'd0;
		endcase
	endfunction
endpackage

### hdl/tgr_datapath.sv
// datapath: config registers, contact state, cordic angle unit, speed test
// depends on tgr_pkg
module tgr_datapath #(
	parameter int COORD_BITS = 10,
	parameter int TIME_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  tgr_pkg::tgr_cmd_t cmd,
	output tgr_pkg::tgr_sts_t sts,
	input  logic cfg_valid,
	input  logic [2:0] cfg_index,
	input  logic [15:0] cfg_data,
	input  logic [2:0] op,
	input  logic [COORD_BITS-1:0] pos_x,
	input  logic [COORD_BITS-1:0] pos_y,
	input  logic [TIME_BITS-1:0] time_ms,
	input  logic skip_touch,
	output logic [2:0] op_q,
	output logic nonnav_q,
	output logic [1:0] gesture_q,
	output logic delivered_q,
	output logic [9:0] tap_x_q,
	output logic [9:0] tap_y_q,
	output logic signed [7:0] steps_q
);
	import tgr_pkg::*;

	localparam int DW = COORD_BITS + 1;      // signed difference
	localparam int CW = COORD_BITS + 36;     // cordic vector width
	localparam int SQW = 2 * COORD_BITS + 2;

	// configuration
	logic [9:0] centre_x_q, centre_y_q, swipe_min_dx_q;
	logic [2:0] handler_mask_q;
	logic [10:0] tap_max_move_q;
	logic [15:0] tap_max_ms_q, grace_ms_q;
	logic [8:0] rotate_min_radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_x_q <= 10'd100;
			centre_y_q <= 10'd114;
			handler_mask_q <= 3'd7;
			tap_max_move_q <= 11'd12;
			tap_max_ms_q <= 16'd350;
			grace_ms_q <= 16'd400;
			swipe_min_dx_q <= 10'd40;
			rotate_min_radius_q <= 9'd24;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CX: centre_x_q <= cfg_data[9:0];
				REG_CY: centre_y_q <= cfg_data[9:0];
				REG_MASK: handler_mask_q <= cfg_data[2:0];
				REG_TMOVE: tap_max_move_q <= cfg_data[10:0];
				REG_TMS: tap_max_ms_q <= cfg_data;
				REG_GRACE: grace_ms_q <= cfg_data;
				REG_SWIPE: swipe_min_dx_q <= cfg_data[9:0];
				REG_RAD: rotate_min_radius_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// captured item
	logic [COORD_BITS-1:0] px_q, py_q;
	logic [TIME_BITS-1:0] now_q;
	logic signed [DW:0] rx_q, ry_q;
	logic [DW:0] mv_q;

	logic [COORD_BITS-1:0] down_x_q, down_y_q, last_x_q, last_y_q;
	logic [TIME_BITS-1:0] attach_time_q, down_time_q, last_angle_time_q;
	logic [DW:0] max_move_q;
	logic [ANGLE_W-1:0] last_angle_q;
	logic signed [12:0] angle_accum_q;
	logic rotated_q;

	logic signed [DW:0] dxm, dym;
	logic [DW:0] adx, ady;
	always_comb begin
		dxm = $signed({2'b0, pos_x}) - $signed({2'b0, down_x_q});
		dym = $signed({2'b0, pos_y}) - $signed({2'b0, down_y_q});
		adx = dxm[DW] ? (DW+1)'(-dxm) : dxm;
		ady = dym[DW] ? (DW+1)'(-dym) : dym;
	end

	// capture and precompute
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op;
			nonnav_q <= skip_touch;
			px_q <= pos_x;
			py_q <= pos_y;
			now_q <= time_ms;
			rx_q <= $signed({2'b0, pos_x}) - $signed((DW+1)'(centre_x_q));
			ry_q <= $signed({2'b0, pos_y}) - $signed((DW+1)'(centre_y_q));
			mv_q <= adx + ady;
		end
	end

	// cordic vectoring, one iteration per cycle
	logic signed [CW-1:0] cx_q, cy_q;
	logic [31:0] cz_q;
	logic [4:0] ci_q;
	logic zero_q;
	logic signed [CW-1:0] xs, ys;
	logic cordic_last, rot_enabled, rot_emit, lift_emit;
	assign xs = cx_q >>> ci_q;
	assign ys = cy_q >>> ci_q;
	assign cordic_last = (ci_q == 5'(CORDIC_N - 1));

	always_ff @(posedge clk) begin
		if (cmd.cordic_init) begin
			ci_q <= '0;
			zero_q <= (rx_q == 0) && (ry_q == 0);
			if (rx_q < 0) begin
				cx_q <= {CW'(-rx_q)} <<< 32;
				cy_q <= {CW'(-ry_q)} <<< 32;
				cz_q <= 32'h8000_0000;
			end else begin
				cx_q <= CW'(rx_q) <<< 32;
				cy_q <= CW'(ry_q) <<< 32;
				cz_q <= '0;
			end
		end else if (cmd.cordic_step) begin
			ci_q <= ci_q + 5'd1;
			if (!cy_q[CW-1]) begin
				cx_q <= cx_q + ys;
				cy_q <= cy_q - xs;
				cz_q <= cz_q + cordic_atan(ci_q);
			end else begin
				cx_q <= cx_q - ys;
				cy_q <= cy_q + xs;
				cz_q <= cz_q - cordic_atan(ci_q);
			end
		end
	end

	logic [31:0] zr;
	logic [ANGLE_W-1:0] angle;
	assign zr = cz_q + 32'd32768;
	assign angle = zero_q ? '0 : zr[31:16];

	// angle difference wrapped into half turn
	logic signed [17:0] dwr, dfull;
	always_comb begin
		dfull = $signed({2'b0, angle}) - $signed({2'b0, last_angle_q});
		if (dfull > 18'sd32768) dwr = dfull - 18'sd65536;
		else if (dfull < -18'sd32768) dwr = dfull + 18'sd65536;
		else dwr = dfull;
	end

	// radius test and speed multiplier:
	// dps = floor(floor(|d|*360000/65536)/dt); dps > k holds
	// exactly when q >= (k+1)*dt, so compare q against 721*dt and 361*dt
	logic [SQW-1:0] r2, rr;
	logic [16:0] ad;
	logic [TIME_BITS-1:0] dt;
	logic [21:0] qd;
	logic [3:0] mult_q;
	logic rad_ok_q;
	logic signed [17:0] d_q;
	logic [TIME_BITS+10:0] t720, t360;
	logic [38:0] qprod;
	always_comb begin
		r2 = SQW'(rx_q * rx_q) + SQW'(ry_q * ry_q);
		rr = SQW'(rotate_min_radius_q * rotate_min_radius_q);
		ad = dwr[17] ? 17'(-dwr) : 17'(dwr);
		dt = now_q - last_angle_time_q;
		if (dt == '0) dt = TIME_BITS'(1);
		qprod = 39'(ad) * 39'd360000;
		qd = qprod[37:16];
		// floor(q/dt) > k  <=>  q >= (k+1)*dt
		t720 = (TIME_BITS+11)'(dt) * (TIME_BITS+11)'(721);
		t360 = (TIME_BITS+11)'(dt) * (TIME_BITS+11)'(361);
	end
	assign rot_enabled = handler_mask_q[2] && rad_ok_q;

	always_ff @(posedge clk) begin
		if (cmd.mult_calc) begin
			rad_ok_q <= !(r2 < rr);
		end
		if (cmd.rot_upd) begin
			d_q <= dwr;
			if ((TIME_BITS+11)'(qd) >= t720) mult_q <= 4'd10;
			else if ((TIME_BITS+11)'(qd) >= t360) mult_q <= 4'd5;
			else mult_q <= 4'd1;
		end
	end

	// accumulator split into whole steps, truncated toward zero
	// (|sum| < 3640 + 32768, so at most 10 steps)
	logic signed [17:0] acc_sum, acc_rem;
	logic [16:0] acc_mag, rem_mag;
	logic [3:0] steps_mag;
	logic signed [4:0] steps;
	always_comb begin
		acc_sum = 18'(angle_accum_q) + d_q;
		acc_mag = acc_sum[17] ? 17'(-acc_sum) : acc_sum[16:0];
		steps_mag = '0;
		for (int k = 1; k <= 10; k++)
			if (acc_mag >= 17'(k * ROT_STEP)) steps_mag = 4'(k);
		rem_mag = acc_mag - 17'(steps_mag) * 17'(ROT_STEP);
		steps = acc_sum[17] ? -$signed({1'b0, steps_mag}) : $signed({1'b0, steps_mag});
		acc_rem = acc_sum[17] ? -$signed({1'b0, rem_mag}) : $signed({1'b0, rem_mag});
	end
	assign rot_emit = (steps != 0) && (max_move_q > (DW+1)'(tap_max_move_q));

	// liftoff classification
	logic signed [DW:0] ldx, ldy;
	logic [DW:0] aldx, aldy;
	logic [TIME_BITS-1:0] since_att, since_down;
	logic tap_ok, swipe_ok, grace_ok;
	always_comb begin
		ldx = $signed({2'b0, last_x_q}) - $signed({2'b0, down_x_q});
		ldy = $signed({2'b0, last_y_q}) - $signed({2'b0, down_y_q});
		aldx = ldx[DW] ? (DW+1)'(-ldx) : ldx;
		aldy = ldy[DW] ? (DW+1)'(-ldy) : ldy;
		since_att = now_q - attach_time_q;
		since_down = now_q - down_time_q;
		grace_ok = !((TIME_BITS+1)'(since_att) < (TIME_BITS+1)'(grace_ms_q));
		tap_ok = (max_move_q <= (DW+1)'(tap_max_move_q)) &&
			((TIME_BITS+1)'(since_down) <= (TIME_BITS+1)'(tap_max_ms_q));
		swipe_ok = (aldx >= (DW+1)'(swipe_min_dx_q)) && ((DW+2)'(aldx) > ((DW+2)'(aldy) << 1));
	end
	assign lift_emit = !rotated_q && grace_ok && (tap_ok || swipe_ok);

	assign sts = '{cordic_last: cordic_last, rot_enabled: rot_enabled,
		rot_emit: rot_emit, lift_emit: lift_emit};

	// contact state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			down_x_q <= '0; down_y_q <= '0; last_x_q <= '0; last_y_q <= '0;
			attach_time_q <= '0; down_time_q <= '0; last_angle_time_q <= '0;
			max_move_q <= '0; last_angle_q <= '0; angle_accum_q <= '0;
			rotated_q <= 1'b0;
		end else begin
			if (cmd.load && op == OP_ATTACH) attach_time_q <= time_ms;
			if (cmd.down_upd) begin
				rotated_q <= 1'b0;
				down_time_q <= now_q;
				down_x_q <= px_q; last_x_q <= px_q;
				down_y_q <= py_q; last_y_q <= py_q;
				max_move_q <= '0;
				angle_accum_q <= '0;
				last_angle_q <= angle;
				last_angle_time_q <= now_q;
			end
			if (cmd.move_upd) begin
				if (mv_q > max_move_q) max_move_q <= mv_q;
				last_x_q <= px_q;
				last_y_q <= py_q;
			end
			if (cmd.rot_upd) begin
				last_angle_q <= angle;
				last_angle_time_q <= now_q;
			end
			if (cmd.acc_upd) begin
				angle_accum_q <= 13'(acc_rem);
				if (rot_emit) rotated_q <= 1'b1;
			end
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.acc_upd) begin
			gesture_q <= G_ROTATE;
			delivered_q <= 1'b1;
			tap_x_q <= '0;
			tap_y_q <= '0;
			steps_q <= 8'(steps) * 8'(mult_q);
		end else if (cmd.lift_upd) begin
			steps_q <= '0;
			if (tap_ok) begin
				gesture_q <= G_TAP;
				delivered_q <= handler_mask_q[0];
				tap_x_q <= 10'(down_x_q);
				tap_y_q <= 10'(down_y_q);
			end else begin
				gesture_q <= ldx[DW] ? G_LEFT : G_RIGHT;
				delivered_q <= handler_mask_q[1];
				tap_x_q <= '0;
				tap_y_q <= '0;
			end
		end
	end
endmodule

### hdl/tgr_ctrl.sv
// controller: sequences one event through the datapath and the handshake
// depends on tgr_pkg
module tgr_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic valid,
	output logic ready,
	output logic out_valid,
	input  logic out_ready,
	input  logic [2:0] op_q,
	input  logic nonnav_q,
	input  tgr_pkg::tgr_sts_t sts,
	output tgr_pkg::tgr_cmd_t cmd
);
	import tgr_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_DISPATCH, S_INIT, S_CORDIC, S_MOVE, S_ROT, S_ACC, S_OUT
	} state_t;

	state_t state_q;
	logic attached_q, active_q, ignore_q, down_q;

	assign ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	// commands decoded from state
	always_comb begin
		cmd = '0;
		cmd.load = valid && ready;
		cmd.cordic_init = (state_q == S_INIT);
		cmd.cordic_step = (state_q == S_CORDIC);
		cmd.mult_calc = (state_q == S_MOVE);
		cmd.down_upd = (state_q == S_CORDIC) && sts.cordic_last && down_q;
		cmd.move_upd = (state_q == S_MOVE);
		cmd.rot_upd = (state_q == S_CORDIC) && sts.cordic_last && !down_q;
		cmd.acc_upd = (state_q == S_ACC);
		cmd.lift_upd = (state_q == S_DISPATCH) && attached_q && op_q == OP_LIFT &&
			active_q && !ignore_q && sts.lift_emit;
	end

	// sequencer and contact flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			attached_q <= 1'b0;
			active_q <= 1'b0;
			ignore_q <= 1'b0;
			down_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (valid) state_q <= S_DISPATCH;
				S_DISPATCH: begin
					state_q <= S_IDLE;
					if (op_q == OP_ATTACH) begin
						attached_q <= 1'b1; active_q <= 1'b0;
					end else if (op_q == OP_DETACH) begin
						attached_q <= 1'b0; active_q <= 1'b0;
					end else if (attached_q) begin
						case (op_q)
							OP_DOWN: begin
								active_q <= 1'b1;
								ignore_q <= nonnav_q;
								down_q <= 1'b1;
								state_q <= S_INIT;
							end
							OP_MOVE: if (active_q && !ignore_q) begin
								down_q <= 1'b0;
								state_q <= S_MOVE;
							end
							OP_LIFT: begin
								active_q <= 1'b0;
								if (cmd.lift_upd) state_q <= S_OUT;
							end
							default: ;
						endcase
					end
				end
				S_MOVE: state_q <= S_ROT;
				S_ROT: state_q <= sts.rot_enabled ? S_INIT : S_IDLE;
				S_INIT: state_q <= S_CORDIC;
				S_CORDIC: if (sts.cordic_last) state_q <= down_q ? S_IDLE : S_ACC;
				S_ACC: state_q <= sts.rot_emit ? S_OUT : S_IDLE;
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### hdl/touch_gesture_recognizer.sv
// touch gesture recognizer top level: controller plus datapath
// a liftoff result is registered in the dispatch state; a rotate result passes the
// move, rot, init, cordic (32-iteration angle unit, one iteration per cycle) and acc states
// one request at a time: ready stays low until the sequence returns to idle, and a
// waiting result holds it off until out_ready takes the result
// reset: arst_n clears the contact state and loads the register defaults
module touch_gesture_recognizer #(
	parameter int COORD_BITS = 10,
	parameter int TIME_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [15:0] cfg_data,
	input  logic valid,
	output logic ready,
	input  logic [2:0] op,
	input  logic [COORD_BITS-1:0] pos_x,
	input  logic [COORD_BITS-1:0] pos_y,
	input  logic [TIME_BITS-1:0] time_ms,
	input  logic skip_touch,
	output logic out_valid,
	input  logic out_ready,
	output logic [1:0] gesture,
	output logic delivered,
	output logic [9:0] tap_x,
	output logic [9:0] tap_y,
	output logic signed [7:0] rotate_steps
);
	import tgr_pkg::*;

	tgr_cmd_t cmd;
	tgr_sts_t sts;
	logic [2:0] op_q;
	logic nonnav_q;

	assign cfg_ready = 1'b1;

	tgr_ctrl u_ctrl (
		.clk, .arst_n, .valid, .ready, .out_valid, .out_ready,
		.op_q, .nonnav_q, .sts, .cmd
	);

	tgr_datapath #(.COORD_BITS(COORD_BITS), .TIME_BITS(TIME_BITS)) u_dp (
		.clk, .arst_n, .cmd, .sts,
		.cfg_valid(cfg_valid && cfg_ready), .cfg_index, .cfg_data,
		.op, .pos_x, .pos_y, .time_ms, .skip_touch,
		.op_q, .nonnav_q,
		.gesture_q(gesture), .delivered_q(delivered),
		.tap_x_q(tap_x), .tap_y_q(tap_y), .steps_q(rotate_steps)
	);

	// no request taken while a result waits
	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> !ready)
		else $error("input taken during result");
	// a rotate result always reports delivered
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && gesture == G_ROTATE) |-> delivered)
		else $error("rotate not delivered");
	// non-rotate results carry no steps
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && gesture != G_ROTATE) |-> (rotate_steps == 8'sd0))
		else $error("steps on non-rotate");
endmodule
